// ===== rtl/bncp_pkg.sv =====
`default_nettype none

package bncp_pkg;

   localparam int LEVEL_W    = 24;
   localparam int FRAC_W     = 16;
   localparam int SPEED_W    = 12;
   localparam int US_W       = 16;
   localparam int LED_W      = 8;
   localparam int PAL_W      = 8;
   localparam int NODE_AW    = 4;
   localparam int MOVE_AW    = 3;
   localparam int NODE_COUNT = 9;
   localparam int MOVE_COUNT = 8;
   localparam int REQ_W      = 48;
   localparam int REQ_USER_W = 2;
   localparam int RSP_W      = 16;

   localparam logic [REQ_USER_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [REQ_USER_W-1:0] OP_TICK  = 2'd1;
   localparam logic [REQ_USER_W-1:0] OP_QUERY = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TICK,
      ST_DRAIN,
      ST_RD_A,
      ST_RD_B,
      ST_MUL_B,
      ST_SUM,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                       vld;
      logic [MOVE_AW-1:0]         idx;
      logic [LEVEL_W-1:0]         level;
      logic signed [SPEED_W-1:0]  speed;
   } wb_type;

endpackage

`default_nettype wire

// ===== rtl/bouncing_node_palette_interpolator.sv =====
// Load: the beat writes the node RAMs and the block stays ready for the next beat.
// Tick: eight node reads issue back to back through a six-stage motion pipeline
//   (one shared multiplier chain) into the node RAMs; the next beat waits until it drains.
// Query: the beat steps through RD_A, RD_B, MUL_B, SUM, DIV and OUT, the result is
//   registered in OUT, and OUT holds while the previous result still waits on rsp_tready.
// Reset: synchronous; a clearing pass over all nine nodes zeroes the node RAMs first.
`default_nettype none

module bouncing_node_palette_interpolator #(
   parameter int LED_COUNT = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // node_index[3:0], node_level[11:4], node_velocity[23:12],
   // elapsed_us[39:24], led_position[47:40]
   input  logic [bncp_pkg::REQ_W-1:0]         req_tdata,
   // op[1:0]
   input  logic [bncp_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // palette_index[7:0], led_echo[15:8]
   output logic [bncp_pkg::RSP_W-1:0]         rsp_tdata
);
   import bncp_pkg::*;

   localparam int SPACING   = LED_COUNT / 8;
   localparam int LAST_LOC  = LED_COUNT - 1;
   localparam int LAST_SPAN = LAST_LOC - 7 * SPACING;
   localparam int SPAN_MAX  = (SPACING > LAST_SPAN) ? SPACING : LAST_SPAN;
   localparam int SPAN_W    = $clog2(SPAN_MAX + 1);
   localparam int LOC_W     = $clog2(LED_COUNT);
   localparam int CMP_W     = (LOC_W > LED_W) ? LOC_W : LED_W;
   localparam int PROD_W    = LEVEL_W + SPAN_W;
   localparam int NUM_W     = SPAN_W + PAL_W;

   state_type state_ff, state_in;

   logic [NODE_AW-1:0]        clr_ff;
   logic [MOVE_AW-1:0]        tick_cnt_ff;
   logic                      issue_vld_ff;
   logic [MOVE_AW-1:0]        issue_idx_ff;
   logic [US_W-1:0]           us_ff;
   logic [MOVE_AW-1:0]        q_seg_ff;
   logic [SPAN_W-1:0]         q_span_ff;
   logic [SPAN_W-1:0]         q_dist_ff;
   logic [LED_W-1:0]          q_led_ff;
   logic [PROD_W-1:0]         prod_a_ff;
   logic [PROD_W-1:0]         prod_b_ff;
   logic                      rsp_vld_ff;
   logic [RSP_W-1:0]          rsp_data_ff;

   logic [LEVEL_W-1:0]        lvl_mem [0:NODE_COUNT-1];
   logic signed [SPEED_W-1:0] spd_mem [0:MOVE_COUNT-1];
   logic [LEVEL_W-1:0]        lvl_rd_ff;
   logic signed [SPEED_W-1:0] spd_rd_ff;

   logic                      lvl_we, spd_we;
   logic [NODE_AW-1:0]        lvl_wa, lvl_ra;
   logic [MOVE_AW-1:0]        spd_wa;
   logic [LEVEL_W-1:0]        lvl_wd;
   logic signed [SPEED_W-1:0] spd_wd;

   logic                      req_beat;
   logic [NODE_AW-1:0]        req_idx;
   logic [LED_W-1:0]          req_level;
   logic signed [SPEED_W-1:0] req_speed;
   logic [US_W-1:0]           req_us;
   logic [LED_W-1:0]          req_led;

   logic [CMP_W-1:0]          led_ext, led_clamp;
   logic [LOC_W-1:0]          l_pos, seg_start;
   logic [MOVE_AW-1:0]        seg;
   logic [SPAN_W-1:0]         span, seg_off;

   logic                      div_start, div_done, rsp_load;
   logic [PROD_W:0]           num_sum;
   logic [NUM_W-1:0]          numer;
   logic [PAL_W-1:0]          quotient;

   wb_type                    mot_wb;
   logic                      mot_busy;

   assign req_idx   = req_tdata[3:0];
   assign req_level = req_tdata[11:4];
   assign req_speed = req_tdata[23:12];
   assign req_us    = req_tdata[39:24];
   assign req_led   = req_tdata[47:40];
   assign req_beat  = req_tvalid & req_tready;

   // segment lookup at the fixed node locations
   always_comb begin
      led_ext   = CMP_W'(req_led);
      led_clamp = (led_ext > CMP_W'(LAST_LOC)) ? CMP_W'(LAST_LOC) : led_ext;
      l_pos     = LOC_W'(led_clamp);
      seg       = '0;
      seg_start = '0;
      for (int i = 1; i < MOVE_COUNT; i++) begin
         if (l_pos >= LOC_W'(i * SPACING)) begin
            seg       = MOVE_AW'(i);
            seg_start = LOC_W'(i * SPACING);
         end
      end
      span    = (seg == MOVE_AW'(MOVE_COUNT - 1)) ? SPAN_W'(LAST_SPAN) : SPAN_W'(SPACING);
      seg_off = SPAN_W'(l_pos - seg_start);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == NODE_AW'(NODE_COUNT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_beat) begin
               if (req_tuser == OP_TICK) begin
                  state_in = ST_TICK;
               end else if (req_tuser == OP_QUERY) begin
                  state_in = ST_RD_A;
               end
            end
         end
         ST_TICK: begin
            if (tick_cnt_ff == MOVE_AW'(MOVE_COUNT - 1)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!mot_busy && !issue_vld_ff) state_in = ST_IDLE;
         end
         ST_RD_A:  state_in = ST_RD_B;
         ST_RD_B:  state_in = ST_MUL_B;
         ST_MUL_B: state_in = ST_SUM;
         ST_SUM:   state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_vld_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs and RAM port control
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      div_start  = (state_ff == ST_SUM);
      rsp_load   = (state_ff == ST_OUT) && (!rsp_vld_ff || rsp_tready);
      lvl_ra     = '0;
      lvl_we     = 1'b0;
      lvl_wa     = '0;
      lvl_wd     = '0;
      spd_we     = 1'b0;
      spd_wa     = '0;
      spd_wd     = '0;
      case (state_ff)
         ST_TICK: lvl_ra = NODE_AW'(tick_cnt_ff);
         ST_RD_A: lvl_ra = NODE_AW'(q_seg_ff);
         ST_RD_B: lvl_ra = NODE_AW'(q_seg_ff) + 1'b1;
         default: lvl_ra = '0;
      endcase
      if (state_ff == ST_CLEAR) begin
         lvl_we = 1'b1;
         lvl_wa = clr_ff;
         spd_we = (clr_ff < NODE_AW'(MOVE_COUNT));
         spd_wa = MOVE_AW'(clr_ff);
      end else if (mot_wb.vld) begin
         lvl_we = 1'b1;
         lvl_wa = NODE_AW'(mot_wb.idx);
         lvl_wd = mot_wb.level;
         spd_we = 1'b1;
         spd_wa = mot_wb.idx;
         spd_wd = mot_wb.speed;
      end else if (req_beat && req_tuser == OP_LOAD && req_idx < NODE_AW'(NODE_COUNT)) begin
         lvl_we = 1'b1;
         lvl_wa = req_idx;
         lvl_wd = {req_level, FRAC_W'(0)};
         spd_we = (req_idx < NODE_AW'(MOVE_COUNT));
         spd_wa = MOVE_AW'(req_idx);
         spd_wd = req_speed;
      end
   end

   always_ff @(posedge clock) begin
      if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
      lvl_rd_ff <= lvl_mem[lvl_ra];
   end

   always_ff @(posedge clock) begin
      if (spd_we) spd_mem[spd_wa] <= spd_wd;
      spd_rd_ff <= spd_mem[tick_cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         tick_cnt_ff  <= '0;
         issue_vld_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_vld_ff <= (state_ff == ST_TICK);
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (req_beat) begin
            tick_cnt_ff <= '0;
         end else if (state_ff == ST_TICK) begin
            tick_cnt_ff <= tick_cnt_ff + 1'b1;
         end
         if (rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      issue_idx_ff <= tick_cnt_ff;
      if (req_beat) begin
         us_ff     <= req_us;
         q_seg_ff  <= seg;
         q_span_ff <= span;
         q_dist_ff <= seg_off;
         q_led_ff  <= req_led;
      end
      if (state_ff == ST_RD_B) prod_a_ff <= PROD_W'(lvl_rd_ff) * PROD_W'(q_span_ff - q_dist_ff);
      if (state_ff == ST_MUL_B) prod_b_ff <= PROD_W'(lvl_rd_ff) * PROD_W'(q_dist_ff);
      if (rsp_load) rsp_data_ff <= {q_led_ff, quotient};
   end

   always_comb begin
      num_sum = {1'b0, prod_a_ff} + {1'b0, prod_b_ff};
      numer   = NUM_W'(num_sum >> FRAC_W);
   end

   bncp_motion u_motion (
      .clock      (clock),
      .reset      (reset),
      .rd_vld     (issue_vld_ff),
      .rd_idx     (issue_idx_ff),
      .rd_level   (lvl_rd_ff),
      .rd_speed   (spd_rd_ff),
      .elapsed_us (us_ff),
      .wb         (mot_wb),
      .busy       (mot_busy)
   );

   bncp_div #(
      .NUM_W (NUM_W),
      .DEN_W (SPAN_W),
      .QUO_W (PAL_W),
      .DIV_A (SPACING),
      .DIV_B (LAST_SPAN)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (numer),
      .denom    (q_span_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/bncp_motion.sv =====
`default_nettype none

module bncp_motion (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rd_vld,
   input  logic [bncp_pkg::MOVE_AW-1:0]         rd_idx,
   input  logic [bncp_pkg::LEVEL_W-1:0]         rd_level,
   input  logic signed [bncp_pkg::SPEED_W-1:0]  rd_speed,
   input  logic [bncp_pkg::US_W-1:0]            elapsed_us,
   output bncp_pkg::wb_type                     wb,
   output logic                                 busy
);
   import bncp_pkg::*;

   localparam int MAG_W    = SPEED_W;
   localparam int P_W      = MAG_W + US_W;
   localparam int RCP_W    = 32;
   localparam int MUL_W    = P_W + RCP_W;
   localparam int RCP_SH   = 35;
   localparam int Q_W      = 24;
   localparam int X_SH     = 10;
   localparam int X_W      = P_W + X_SH;
   localparam int SUM_W    = LEVEL_W + 3;

   // floor(2^45 / 15625); 65536/1e6 == 1024/15625
   localparam logic [RCP_W-1:0]      RECIP        = 32'd2251799813;
   localparam logic [13:0]           US_DIV       = 14'd15625;
   localparam logic signed [SUM_W-1:0] TOP_LEVEL    = 27'sd16711680;
   localparam logic signed [SUM_W-1:0] MIRROR_LEVEL = 27'sd33488896;
   localparam logic signed [SPEED_W-1:0] SPEED_MIN  = 12'sh800;
   localparam logic signed [SPEED_W-1:0] SPEED_MAX  = 12'sh7ff;

   typedef struct packed {
      logic [MOVE_AW-1:0]        idx;
      logic [LEVEL_W-1:0]        lev;
      logic signed [SPEED_W-1:0] spd;
   } node_type;

   function automatic logic signed [SPEED_W-1:0] neg_speed(input logic signed [SPEED_W-1:0] v);
      if (v == SPEED_MIN) begin
         return SPEED_MAX;
      end else begin
         return -v;
      end
   endfunction

   logic                 s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, s6_vld_ff;
   node_type             s1_node_ff, s2_node_ff, s3_node_ff, s4_node_ff, s5_node_ff;
   logic [P_W-1:0]       s1_p_ff, s2_p_ff, s3_p_ff;
   logic [Q_W-1:0]       s2_q_ff, s3_q_ff, s4_delta_ff;
   logic [X_W-1:0]       s3_t_ff;
   logic signed [SUM_W-1:0] s5_sum_ff;
   wb_type               s6_wb_ff;

   logic [MAG_W-1:0]     mag_in;
   logic [P_W-1:0]       p_in;
   logic [MUL_W-1:0]     rcp_prod;
   logic [Q_W-1:0]       q_in;
   logic [X_W-1:0]       t_in;
   logic [X_W-1:0]       x_val;
   logic [X_W-1:0]       rem_val;
   logic [Q_W-1:0]       delta_in;
   logic signed [SUM_W-1:0] dext;
   logic signed [SUM_W-1:0] sum_in;
   logic signed [SUM_W-1:0] lev_a, lev_b;
   logic signed [SPEED_W-1:0] spd_a, spd_b;
   wb_type               wb_in;

   always_comb begin
      mag_in = rd_speed[SPEED_W-1] ? MAG_W'(~rd_speed + 1'b1) : MAG_W'(rd_speed);
      p_in   = P_W'(mag_in) * P_W'(elapsed_us);
   end

   always_comb begin
      rcp_prod = MUL_W'(s1_p_ff) * MUL_W'(RECIP);
      q_in     = rcp_prod[RCP_SH +: Q_W];
   end

   assign t_in = X_W'(s2_q_ff) * X_W'(US_DIV);

   always_comb begin
      x_val    = {s3_p_ff, X_SH'(0)};
      rem_val  = x_val - s3_t_ff;
      delta_in = s3_q_ff + Q_W'(rem_val >= X_W'(US_DIV));
   end

   always_comb begin
      dext   = SUM_W'(s4_delta_ff);
      sum_in = $signed(SUM_W'(s4_node_ff.lev))
             + (s4_node_ff.spd[SPEED_W-1] ? -dext : dext);
   end

   always_comb begin
      lev_a = s5_sum_ff;
      spd_a = s5_node_ff.spd;
      if (lev_a < 0) begin
         lev_a = -lev_a;
         spd_a = neg_speed(spd_a);
      end
      lev_b = lev_a;
      spd_b = spd_a;
      if (lev_a > TOP_LEVEL) begin
         lev_b = MIRROR_LEVEL - lev_a;
         spd_b = neg_speed(spd_a);
      end
      if (lev_b < 0) begin
         lev_b = '0;
      end
      wb_in.vld   = s5_vld_ff;
      wb_in.idx   = s5_node_ff.idx;
      wb_in.level = lev_b[LEVEL_W-1:0];
      wb_in.speed = spd_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= rd_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_node_ff.idx <= rd_idx;
      s1_node_ff.lev <= rd_level;
      s1_node_ff.spd <= rd_speed;
      s1_p_ff        <= p_in;
      s2_node_ff     <= s1_node_ff;
      s2_p_ff        <= s1_p_ff;
      s2_q_ff        <= q_in;
      s3_node_ff     <= s2_node_ff;
      s3_p_ff        <= s2_p_ff;
      s3_q_ff        <= s2_q_ff;
      s3_t_ff        <= t_in;
      s4_node_ff     <= s3_node_ff;
      s4_delta_ff    <= delta_in;
      s5_node_ff     <= s4_node_ff;
      s5_sum_ff      <= sum_in;
      s6_wb_ff       <= wb_in;
   end

   always_comb begin
      wb     = s6_wb_ff;
      wb.vld = s6_vld_ff;
   end

   assign busy = s1_vld_ff | s2_vld_ff | s3_vld_ff | s4_vld_ff | s5_vld_ff | s6_vld_ff;

endmodule

`default_nettype wire

// ===== rtl/bncp_div.sv =====
`default_nettype none

module bncp_div #(
   parameter int NUM_W = 13,
   parameter int DEN_W = 5,
   parameter int QUO_W = 8,
   parameter int DIV_A = 16,
   parameter int DIV_B = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [QUO_W-1:0] quotient
);

   localparam int SH_W  = NUM_W + DEN_W;
   localparam int RCP_W = SH_W + 1;
   localparam int PRD_W = NUM_W + RCP_W;

   // ceil(2^SH_W / d) gives an exact floor for any numer below 2^NUM_W, d <= 2^DEN_W
   localparam longint RCP_A_L = ((longint'(1) << SH_W) + longint'(DIV_A) - 1) / longint'(DIV_A);
   localparam longint RCP_B_L = ((longint'(1) << SH_W) + longint'(DIV_B) - 1) / longint'(DIV_B);
   localparam logic [RCP_W-1:0] RCP_A = RCP_W'(RCP_A_L);
   localparam logic [RCP_W-1:0] RCP_B = RCP_W'(RCP_B_L);

   logic             done_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [RCP_W-1:0] rcp;
   logic [PRD_W-1:0] prod;

   // numer < denom << QUO_W, so the quotient fits
   always_comb begin
      rcp  = (denom == DEN_W'(DIV_B)) ? RCP_B : RCP_A;
      prod = PRD_W'(numer) * PRD_W'(rcp);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) quo_ff <= prod[SH_W +: QUO_W];
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire
